// ===== rtl/rtc_pkg.sv =====
`timescale 1ns / 1ps

package rtc_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int IDX_W       = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
   localparam int CNT_OUT_W   = 7;
   localparam int HALF_W      = 16;
   localparam int REC_W       = 2 * HALF_W;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;
   localparam int KIND_W      = 3;

   localparam logic [HALF_W-1:0] EMPTY_HALF = 16'hFFFF;
   localparam logic [REC_W-1:0]  EMPTY_REC  = {EMPTY_HALF, EMPTY_HALF};

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE       = 3'd0,
      KIND_READ        = 3'd1,
      KIND_DELETE      = 3'd2,
      KIND_DEL_COMPACT = 3'd3,
      KIND_COMPACT     = 3'd4,
      KIND_CLEAR       = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_READ,
      CMD_DELETE,
      CMD_DEL_COMPACT,
      CMD_COMPACT,
      CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [IDX_W-1:0] idx;
      logic [REC_W-1:0] rec;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/rtc_front.sv =====
`timescale 1ns / 1ps

module rtc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rtc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rtc_pkg::KIND_W-1:0]       req_tuser,
   output logic                             cmd_valid,
   output rtc_pkg::cmd_type                 cmd,
   input  logic                             cmd_pop
);
   import rtc_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;
   logic       in_range;
   logic [HALF_W-1:0] entry_index;
   cmd_type    cls;

   assign entry_index = req_tdata[HALF_W-1:0];
   assign in_range    = entry_index < HALF_W'(TABLE_SLOTS);

   // classify the transfer into a back-end command
   always_comb begin
      cls.idx = entry_index[IDX_W-1:0];
      cls.rec = req_tdata[3*HALF_W-1:HALF_W];
      cls.op  = CMD_NOP;
      unique case (kind_type'(req_tuser))
         KIND_WRITE:       cls.op = in_range ? CMD_WRITE : CMD_NOP;
         KIND_READ:        cls.op = in_range ? CMD_READ : CMD_NOP;
         KIND_DELETE:      cls.op = in_range ? CMD_DELETE : CMD_NOP;
         KIND_DEL_COMPACT: cls.op = in_range ? CMD_DEL_COMPACT : CMD_NOP;
         KIND_COMPACT:     cls.op = CMD_COMPACT;
         KIND_CLEAR:       cls.op = CMD_CLEAR;
         default:          cls.op = CMD_NOP;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2);
   assign cmd_valid  = (fill_ff != 2'd0);
   assign cmd        = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = cmd_pop & cmd_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/rtc_back.sv =====
`timescale 1ns / 1ps

module rtc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  rtc_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rtc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [0:0]                       rsp_tuser
);
   import rtc_pkg::*;

   logic [REC_W-1:0] record_mem [TABLE_SLOTS];
   logic [REC_W-1:0] mem_q_ff;

   state_type        state_ff;
   state_type        state_in;
   logic [TABLE_SLOTS-1:0] occ_ff;
   logic [TABLE_SLOTS-1:0] occ_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [IDX_W-1:0] src_ff;
   logic [IDX_W-1:0] src_in;
   logic [IDX_W-1:0] dst_ff;
   logic [IDX_W-1:0] dst_in;
   logic             pend_ff;
   logic             pend_in;
   logic [IDX_W-1:0] pend_dst_ff;
   logic [IDX_W-1:0] pend_dst_in;
   logic             res_read_ff;
   logic             res_read_in;
   logic             res_hit_ff;
   logic             res_hit_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic             rsp_empty_ff;
   logic             rsp_empty_in;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;
   logic             new_occ;
   logic [REC_W-1:0] res_rec;

   assign new_occ = (cmd.rec != EMPTY_REC);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      count_in     = count_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pend_in      = 1'b0;
      pend_dst_in  = pend_dst_ff;
      res_read_in  = res_read_ff;
      res_hit_in   = res_hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cmd.idx;
      wr_en        = 1'b0;
      wr_addr      = cmd.idx;
      wr_data      = cmd.rec;
      res_rec      = '0;

      // deferred move of the last record picked up by the sweep
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_dst_ff;
         wr_data = mem_q_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               res_read_in = 1'b0;
               res_hit_in  = 1'b0;
               src_in      = '0;
               dst_in      = '0;
               state_in    = ST_DONE;
               unique case (cmd.op)
                  CMD_WRITE: begin
                     wr_en            = new_occ;
                     occ_in[cmd.idx]  = new_occ;
                     count_in         = count_ff - CNT_W'(occ_ff[cmd.idx])
                                        + CNT_W'(new_occ);
                  end
                  CMD_READ: begin
                     rd_en       = 1'b1;
                     res_read_in = 1'b1;
                     res_hit_in  = occ_ff[cmd.idx];
                  end
                  CMD_DELETE: begin
                     occ_in[cmd.idx] = 1'b0;
                     count_in        = count_ff - CNT_W'(occ_ff[cmd.idx]);
                  end
                  CMD_DEL_COMPACT: begin
                     if (occ_ff[cmd.idx]) begin
                        occ_in[cmd.idx] = 1'b0;
                        count_in        = count_ff - CNT_W'(1);
                        state_in        = ST_SWEEP;
                     end
                  end
                  CMD_COMPACT: begin
                     state_in = ST_SWEEP;
                  end
                  CMD_CLEAR: begin
                     occ_in   = '0;
                     count_in = '0;
                  end
                  CMD_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (occ_ff[src_ff]) begin
               dst_in = dst_ff + IDX_W'(1);
               if (src_ff != dst_ff) begin
                  rd_en          = 1'b1;
                  rd_addr        = src_ff;
                  occ_in[dst_ff] = 1'b1;
                  occ_in[src_ff] = 1'b0;
                  pend_in        = 1'b1;
                  pend_dst_in    = dst_ff;
               end
            end
            if (src_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               src_in = src_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (res_read_ff) begin
                  res_rec = res_hit_ff ? mem_q_ff : EMPTY_REC;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, CNT_OUT_W'(count_ff), res_rec};
               rsp_empty_in = res_read_ff & ~res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      pend_dst_ff  <= pend_dst_in;
      res_read_ff  <= res_read_in;
      res_hit_ff   <= res_hit_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // record memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         record_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= record_mem[rd_addr];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_empty_ff;

endmodule

// ===== rtl/record_table_with_compaction_top.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata: entry_index, first_value, second_value
//                                       tuser: kind
// rsp       out  rsp_tvalid/rsp_tready  tdata: read_first, read_second, occupied_count
//                                       tuser: slot_empty
//
// write, read, delete, clear, unused kinds and a delete-and-compact that removes nothing
// go from the command queue through ST_IDLE and ST_DONE into the result register
// compact and a delete-and-compact that removes a record also pass through ST_SWEEP:
// the sweep reads one slot per cycle through the single read port of the record memory
// reset clears the per-slot occupancy flags at once, so no clearing pass follows it
// a 2-deep command queue and the result register let either side stall on its own

module record_table_with_compaction_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rtc_pkg::REQ_DATA_W-1:0]   req_tdata,  // entry_index, first_value, second_value
   input  logic [rtc_pkg::KIND_W-1:0]       req_tuser,  // kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rtc_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // read_first, read_second, occupied_count, pad
   output logic [0:0]                       rsp_tuser   // slot_empty
);
   import rtc_pkg::*;

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   rtc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   rtc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   a_empty_flag_matches_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[REC_W-1:0] == EMPTY_REC)))
      else $error("slot_empty disagrees with read data");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result transfer offered right after reset");

   a_pop_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty queue");
`endif

endmodule

// ===== bench/record_table_with_compaction_top_tb.sv =====
`timescale 1ns / 1ps

module record_table_with_compaction_top_tb;
   import rtc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
   localparam int                CYCLE_LIMIT   = 400000;
   localparam int                PHASE_ITEMS   = 315;

   typedef struct packed {
      logic [HALF_W-1:0]    read_first;
      logic [HALF_W-1:0]    read_second;
      logic                 slot_empty;
      logic [CNT_OUT_W-1:0] occupied_count;
   } table_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // entry_index, first_value, second_value
   logic [KIND_W-1:0]     req_tuser = '0;  // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // read_first, read_second, occupied_count, pad
   logic [0:0]            rsp_tuser;       // slot_empty

   logic [REC_W-1:0] records [TABLE_SLOTS];
   table_reply_type  table_replies_q [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   logic             rsp_hold = 1'b0;

   record_table_with_compaction_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- table model

   function automatic void compact_records();
      int dst;
      dst = 0;
      for (int src = 0; src < TABLE_SLOTS; src++) begin
         if (records[src] != EMPTY_REC) begin
            if (src != dst) begin
               records[dst] = records[src];
               records[src] = EMPTY_REC;
            end
            dst++;
         end
      end
   endfunction

   function automatic table_reply_type table_apply(logic [KIND_W-1:0] kind, logic [15:0] idx,
                                                   logic [HALF_W-1:0] first_value,
                                                   logic [HALF_W-1:0] second_value);
      table_reply_type  reply;
      logic             hit;
      logic [IDX_W-1:0] slot;
      int               used;
      reply = '0;
      hit   = idx < TABLE_SLOTS;
      slot  = idx[IDX_W-1:0];
      case (kind)
         KIND_WRITE: begin
            if (hit) records[slot] = {second_value, first_value};
         end
         KIND_READ: begin
            if (hit) begin
               reply.read_first  = records[slot][HALF_W-1:0];
               reply.read_second = records[slot][REC_W-1:HALF_W];
               reply.slot_empty  = records[slot] == EMPTY_REC;
            end
         end
         KIND_DELETE: begin
            if (hit) records[slot] = EMPTY_REC;
         end
         KIND_DEL_COMPACT: begin
            if (hit && records[slot] != EMPTY_REC) begin
               records[slot] = EMPTY_REC;
               compact_records();
            end
         end
         KIND_COMPACT: begin
            compact_records();
         end
         KIND_CLEAR: begin
            for (int i = 0; i < TABLE_SLOTS; i++) records[i] = EMPTY_REC;
         end
         default: begin
         end
      endcase
      used = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) if (records[i] != EMPTY_REC) used++;
      reply.occupied_count = used[CNT_OUT_W-1:0];
      return reply;
   endfunction

   // ---------------------------------------------------------------- result check

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 100)
         $display("mismatch %s at cycle %0d: got %0h expected %0h", what, cycle_count, got,
                  want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      table_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (table_replies_q.size() == 0) begin
            report_mismatch("transfer with nothing pending", rsp_tdata[31:0], '0);
         end else begin
            want = table_replies_q.pop_front();
            if (rsp_tdata[15:0] !== want.read_first)
               report_mismatch("read_first", 32'(rsp_tdata[15:0]), 32'(want.read_first));
            if (rsp_tdata[31:16] !== want.read_second)
               report_mismatch("read_second", 32'(rsp_tdata[31:16]), 32'(want.read_second));
            if (rsp_tdata[38:32] !== want.occupied_count)
               report_mismatch("occupied_count", 32'(rsp_tdata[38:32]),
                               32'(want.occupied_count));
            if (rsp_tuser[0] !== want.slot_empty)
               report_mismatch("slot_empty", 32'(rsp_tuser[0]), 32'(want.slot_empty));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(logic [KIND_W-1:0] kind, logic [15:0] idx,
                            logic [HALF_W-1:0] first_value, logic [HALF_W-1:0] second_value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {second_value, first_value, idx};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_replies_q.push_back(table_apply(kind, idx, first_value, second_value));
   endtask

   task automatic wait_replies_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (table_replies_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_items(int count);
      int                pick;
      logic [KIND_W-1:0] kind;
      logic [15:0]       idx;
      logic [HALF_W-1:0] first_value;
      logic [HALF_W-1:0] second_value;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 36)      kind = KIND_WRITE;
         else if (pick < 62) kind = KIND_READ;
         else if (pick < 74) kind = KIND_DELETE;
         else if (pick < 84) kind = KIND_DEL_COMPACT;
         else if (pick < 90) kind = KIND_COMPACT;
         else if (pick < 92) kind = KIND_CLEAR;
         else if (pick < 96) kind = KIND_SPARE_LO;
         else                kind = KIND_SPARE_HI;
         pick = $urandom_range(0, 99);
         if (pick < 85)      idx = $urandom_range(0, TABLE_SLOTS - 1);
         else if (pick < 95) idx = $urandom_range(TABLE_SLOTS, 65535);
         else                idx = 16'hFFFF;
         first_value  = $urandom_range(0, 65535);
         second_value = $urandom_range(0, 65535);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            first_value  = EMPTY_HALF;
            second_value = EMPTY_HALF;
         end else if (pick < 13) begin
            first_value = EMPTY_HALF;
         end else if (pick < 18) begin
            second_value = EMPTY_HALF;
         end else if (pick < 22) begin
            first_value  = '0;
            second_value = '0;
         end
         send_item(kind, idx, first_value, second_value);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_item(KIND_READ, 16'd0, '0, '0);
      send_item(KIND_WRITE, 16'd0, 16'h0000, 16'h0000);
      send_item(KIND_WRITE, 16'd63, 16'hFFFF, 16'h0000);
      send_item(KIND_WRITE, 16'd1, 16'h0000, 16'hFFFF);
      send_item(KIND_WRITE, 16'd2, 16'hFFFF, 16'hFFFF);
      send_item(KIND_WRITE, 16'd64, 16'h1234, 16'h5678);
      send_item(KIND_WRITE, 16'hFFFF, 16'hAAAA, 16'h5555);
      send_item(KIND_READ, 16'd63, '0, '0);
      send_item(KIND_READ, 16'd1, '0, '0);
      send_item(KIND_READ, 16'd2, '0, '0);
      send_item(KIND_READ, 16'd64, '0, '0);
      send_item(KIND_READ, 16'hFFFF, '0, '0);
      send_item(KIND_DELETE, 16'd1, '0, '0);
      send_item(KIND_DELETE, 16'hFFFF, '0, '0);
      send_item(KIND_DEL_COMPACT, 16'd2, '0, '0);
      send_item(KIND_DEL_COMPACT, 16'd0, '0, '0);
      send_item(KIND_DEL_COMPACT, 16'd64, '0, '0);
      send_item(KIND_READ, 16'd0, '0, '0);
      send_item(KIND_WRITE, 16'd40, 16'hBEEF, 16'hCAFE);
      send_item(KIND_COMPACT, 16'd0, '0, '0);
      send_item(KIND_READ, 16'd1, '0, '0);
      send_item(KIND_SPARE_LO, 16'd1, 16'h1111, 16'h2222);
      send_item(KIND_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_CLEAR, 16'd0, '0, '0);
      send_item(KIND_READ, 16'd0, '0, '0);
      wait_replies_done();
   endtask

   task automatic test_steady_stream();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random_items(PHASE_ITEMS);
      wait_replies_done();
   endtask

   task automatic test_sparse_requests();
      send_idle_pct  = 69;
      recv_stall_pct = 0;
      send_random_items(PHASE_ITEMS);
      wait_replies_done();
   endtask

   task automatic test_slow_consumer();
      send_idle_pct  = 0;
      recv_stall_pct = 69;
      send_random_items(PHASE_ITEMS);
      wait_replies_done();
   endtask

   task automatic test_light_idling();
      send_idle_pct  = 8;
      recv_stall_pct = 8;
      send_random_items(PHASE_ITEMS);
      wait_replies_done();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         send_random_items(30);
      join
      // hold the sender until the table has answered everything
      wait_replies_done();
      send_random_items(30);
      wait_replies_done();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) records[i] = EMPTY_REC;
      @(posedge clock);
      test_directed_cases();
      test_steady_stream();
      test_sparse_requests();
      test_slow_consumer();
      test_light_idling();
      test_backpressure();
      repeat (TABLE_SLOTS + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rtc_pkg.sv
rtl/rtc_front.sv
rtl/rtc_back.sv
rtl/record_table_with_compaction_top.sv
bench/record_table_with_compaction_top_tb.sv
